@@ rtl/dbs_pkg.sv @@
package dbs_pkg;

	// Default sizes of the block
	localparam int DEF_MAX_DIM    = 64;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int DEF_FRAC_BITS  = 8;
	localparam int DEF_MAX_KERNEL = 16;

	// Register and field widths fixed by the programming interface
	localparam int DIM_REG_W   = 7;
	localparam int SMALL_REG_W = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 7;
	localparam int OFF_W       = 16;

	// Pixel store is split over four banks by row and column parity
	localparam int NBANK = 4;

	// Result queue depth, also the number of samples that may be in flight
	localparam int FIFO_DEPTH = 16;

	// Register reset values
	localparam logic [DIM_REG_W-1:0]   RST_IMAGE_DIM = DIM_REG_W'(64);
	localparam logic [SMALL_REG_W-1:0] RST_PAD       = '0;
	localparam logic [SMALL_REG_W-1:0] RST_STEP      = SMALL_REG_W'(1);

	// Command codes carried in the input tuser
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_HEIGHT,
		REG_IMAGE_WIDTH,
		REG_PAD_ROWS,
		REG_PAD_COLS,
		REG_STRIDE_ROWS,
		REG_STRIDE_COLS,
		REG_DILATION_ROWS,
		REG_DILATION_COLS
	} cfg_reg_t;

	// Sample control travelling alongside the pixel read data
	typedef struct packed {
		logic valid;
		logic in_img;
		logic row_odd;
		logic col_odd;
	} smp_ctl_t;

	function automatic int clog2_min1(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

@@ rtl/dbs_ram.sv @@
module dbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/dbs_front.sv @@
module dbs_front import dbs_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int MAX_KERNEL = DEF_MAX_KERNEL,
	localparam int POS_W   = clog2_min1(MAX_DIM),
	localparam int TAP_W   = clog2_min1(MAX_KERNEL),
	localparam int ADDR_W  = clog2_min1(MAX_DIM * MAX_DIM),
	localparam int HALF    = (MAX_DIM + 1) / 2,
	localparam int BANK_AW = clog2_min1(HALF * HALF)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// register writes
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	// accepted request
	input  logic                          in_take,
	input  logic                          in_cmd,
	input  logic [ADDR_W-1:0]             in_pixel_addr,
	input  logic [PIXEL_BITS-1:0]         in_pixel_value,
	input  logic [POS_W-1:0]              in_out_row,
	input  logic [POS_W-1:0]              in_out_col,
	input  logic [TAP_W-1:0]              in_tap_row,
	input  logic [TAP_W-1:0]              in_tap_col,
	input  logic [OFF_W-1:0]              in_offset_rows,
	input  logic [OFF_W-1:0]              in_offset_cols,
	// pixel bank accesses
	output logic [NBANK-1:0]              bank_we,
	output logic [NBANK-1:0][BANK_AW-1:0] bank_addr,
	output logic [PIXEL_BITS-1:0]         bank_wdata,
	// sample control aligned with bank read data
	output smp_ctl_t                      ctl_s4,
	output logic [FRAC_BITS-1:0]          fr_s4,
	output logic [FRAC_BITS-1:0]          fc_s4
);

	localparam int OS_W   = POS_W + SMALL_REG_W;
	localparam int TD_W   = TAP_W + SMALL_REG_W;
	localparam int BASE_W = ((OS_W > TD_W) ? OS_W : TD_W) + 2;
	localparam int P_W    = ((BASE_W + FRAC_BITS > OFF_W) ? BASE_W + FRAC_BITS : OFF_W) + 1;
	localparam int DV_W   = clog2_min1(MAX_DIM + 1);
	localparam int CMP_W  = (DIM_REG_W > DV_W) ? DIM_REG_W : DV_W;
	localparam int HALF_W = clog2_min1(HALF);
	localparam int Q_W    = POS_W + 1;

	// Exact division of the pixel address by the row pitch: multiply by a
	// rounded-up reciprocal and keep the top bits
	localparam int    DIV_K = ADDR_W + $clog2(MAX_DIM);
	localparam int    M_W   = ADDR_W + 1;
	localparam longint DIV_M = ((longint'(1) << DIV_K) + MAX_DIM - 1) / MAX_DIM;
	localparam logic [M_W-1:0]     RECIP   = M_W'(DIV_M);
	localparam logic [ADDR_W-1:0]  PITCH_A = ADDR_W'(MAX_DIM);
	localparam logic [Q_W-1:0]     PITCH_Q = Q_W'(MAX_DIM);
	localparam logic [CMP_W-1:0]   DIM_MAX = CMP_W'(MAX_DIM);
	localparam logic [BANK_AW-1:0] HALF_A  = BANK_AW'(HALF);

	// Configuration registers
	logic [DIM_REG_W-1:0]   height_q, width_q;
	logic [SMALL_REG_W-1:0] pad_r_q, pad_c_q, str_r_q, str_c_q, dil_r_q, dil_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= RST_IMAGE_DIM;
			width_q  <= RST_IMAGE_DIM;
			pad_r_q  <= RST_PAD;
			pad_c_q  <= RST_PAD;
			str_r_q  <= RST_STEP;
			str_c_q  <= RST_STEP;
			dil_r_q  <= RST_STEP;
			dil_c_q  <= RST_STEP;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_HEIGHT:  height_q <= cfg_data;
				REG_IMAGE_WIDTH:   width_q  <= cfg_data;
				REG_PAD_ROWS:      pad_r_q  <= cfg_data[SMALL_REG_W-1:0];
				REG_PAD_COLS:      pad_c_q  <= cfg_data[SMALL_REG_W-1:0];
				REG_STRIDE_ROWS:   str_r_q  <= cfg_data[SMALL_REG_W-1:0];
				REG_STRIDE_COLS:   str_c_q  <= cfg_data[SMALL_REG_W-1:0];
				REG_DILATION_ROWS: dil_r_q  <= cfg_data[SMALL_REG_W-1:0];
				REG_DILATION_COLS: dil_c_q  <= cfg_data[SMALL_REG_W-1:0];
			endcase
		end
	end

	// Image size saturated to the store size, and the last valid position
	logic [CMP_W-1:0] h_ext, w_ext, h_eff, w_eff;
	logic [P_W-1:0]   lim_r, lim_c;
	logic             dims_ok;

	always_comb begin
		h_ext   = CMP_W'(height_q);
		w_ext   = CMP_W'(width_q);
		h_eff   = (h_ext > DIM_MAX) ? DIM_MAX : h_ext;
		w_eff   = (w_ext > DIM_MAX) ? DIM_MAX : w_ext;
		lim_r   = P_W'(h_eff - CMP_W'(1)) << FRAC_BITS;
		lim_c   = P_W'(w_eff - CMP_W'(1)) << FRAC_BITS;
		dims_ok = (h_eff != '0) && (w_eff != '0);
	end

	// Stage 1: request capture
	logic                     smp_s1, wr_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic [PIXEL_BITS-1:0]    pix_s1;
	logic [POS_W-1:0]         orow_s1, ocol_s1;
	logic [TAP_W-1:0]         trow_s1, tcol_s1;
	logic signed [OFF_W-1:0]  offr_s1, offc_s1;

	// Stage 2: products
	logic                     smp_s2, wr_s2;
	logic [OS_W-1:0]          osr_s2, osc_s2;
	logic [TD_W-1:0]          tdr_s2, tdc_s2;
	logic signed [OFF_W-1:0]  offr_s2, offc_s2;
	logic [ADDR_W-1:0]        addr_s2;
	logic [Q_W-1:0]           q_s2;
	logic [PIXEL_BITS-1:0]    pix_s2;

	// Stage 3: fixed-point positions, write row and column
	logic                     smp_s3, wr_s3, wen_s3;
	logic signed [P_W-1:0]    pr_s3, pc_s3;
	logic [POS_W-1:0]         row_s3, col_s3;
	logic [PIXEL_BITS-1:0]    pix_s3;

	// Stage 3 decode: in-image test, neighbour indices, bank rows/columns
	smp_ctl_t             ctl_d;
	logic [POS_W-1:0]     r0, c0;
	logic [FRAC_BITS-1:0] fr_d, fc_d;
	logic                 in_img;
	logic [HALF_W-1:0]    s_ev_r, s_od_r, s_ev_c, s_od_c, w_rh, w_ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1 <= 1'b0;
			wr_s1  <= 1'b0;
			smp_s2 <= 1'b0;
			wr_s2  <= 1'b0;
			smp_s3 <= 1'b0;
			wr_s3  <= 1'b0;
			wen_s3 <= 1'b0;
			ctl_s4 <= '0;
		end else begin
			smp_s1 <= in_take && (in_cmd == CMD_SAMPLE);
			wr_s1  <= in_take && (in_cmd == CMD_WRITE);
			smp_s2 <= smp_s1;
			wr_s2  <= wr_s1;
			smp_s3 <= smp_s2;
			wr_s3  <= wr_s2;
			wen_s3 <= wr_s2 && (q_s2 < PITCH_Q);
			ctl_s4 <= ctl_d;
		end
	end

	// Base term per axis and write address split
	logic [ADDR_W+M_W-1:0]    div_prod;
	logic signed [BASE_W-1:0] base_r, base_c;
	logic [ADDR_W-1:0]        row_off;

	always_comb begin
		div_prod = (ADDR_W + M_W)'(addr_s1) * (ADDR_W + M_W)'(RECIP);
		base_r   = BASE_W'(osr_s2) - BASE_W'(pad_r_q) + BASE_W'(tdr_s2);
		base_c   = BASE_W'(osc_s2) - BASE_W'(pad_c_q) + BASE_W'(tdc_s2);
		row_off  = ADDR_W'(q_s2) * PITCH_A;
	end

	always_ff @(posedge clk) begin
		addr_s1 <= in_pixel_addr;
		pix_s1  <= in_pixel_value;
		orow_s1 <= in_out_row;
		ocol_s1 <= in_out_col;
		trow_s1 <= in_tap_row;
		tcol_s1 <= in_tap_col;
		offr_s1 <= in_offset_rows;
		offc_s1 <= in_offset_cols;

		osr_s2  <= OS_W'(orow_s1) * OS_W'(str_r_q);
		osc_s2  <= OS_W'(ocol_s1) * OS_W'(str_c_q);
		tdr_s2  <= TD_W'(trow_s1) * TD_W'(dil_r_q);
		tdc_s2  <= TD_W'(tcol_s1) * TD_W'(dil_c_q);
		offr_s2 <= offr_s1;
		offc_s2 <= offc_s1;
		addr_s2 <= addr_s1;
		q_s2    <= div_prod[DIV_K +: Q_W];
		pix_s2  <= pix_s1;

		pr_s3   <= (P_W'(base_r) <<< FRAC_BITS) + P_W'(offr_s2);
		pc_s3   <= (P_W'(base_c) <<< FRAC_BITS) + P_W'(offc_s2);
		row_s3  <= POS_W'(q_s2);
		col_s3  <= POS_W'(addr_s2 - row_off);
		pix_s3  <= pix_s2;

		fr_s4   <= fr_d;
		fc_s4   <= fc_d;
	end

	// In-image test, neighbour indices and per-parity bank rows/columns
	always_comb begin
		in_img = dims_ok && !pr_s3[P_W-1] && !pc_s3[P_W-1] &&
			($unsigned(pr_s3) <= lim_r) && ($unsigned(pc_s3) <= lim_c);
		r0     = pr_s3[FRAC_BITS +: POS_W];
		c0     = pc_s3[FRAC_BITS +: POS_W];
		fr_d   = pr_s3[FRAC_BITS-1:0];
		fc_d   = pc_s3[FRAC_BITS-1:0];
		// the even neighbour row is r0 rounded up to even, the odd one r0 rounded up to odd
		s_ev_r = HALF_W'(((POS_W + 1)'(r0) + (POS_W + 1)'(r0[0])) >> 1);
		s_od_r = HALF_W'(r0 >> 1);
		s_ev_c = HALF_W'(((POS_W + 1)'(c0) + (POS_W + 1)'(c0[0])) >> 1);
		s_od_c = HALF_W'(c0 >> 1);
		w_rh   = HALF_W'(row_s3 >> 1);
		w_ch   = HALF_W'(col_s3 >> 1);

		ctl_d.valid   = smp_s3;
		ctl_d.in_img  = in_img;
		ctl_d.row_odd = r0[0];
		ctl_d.col_odd = c0[0];
	end

	// Bank addresses: writes go to one bank, samples read all four
	for (genvar g = 0; g < NBANK; g++) begin : g_bank
		localparam logic [1:0] KB = 2'(g);
		logic [HALF_W-1:0] rsel, csel;

		always_comb begin
			if (wr_s3) begin
				rsel = w_rh;
				csel = w_ch;
			end else begin
				rsel = KB[1] ? s_od_r : s_ev_r;
				csel = KB[0] ? s_od_c : s_ev_c;
			end
		end

		assign bank_addr[g] = BANK_AW'(rsel) * HALF_A + BANK_AW'(csel);
		assign bank_we[g]   = wen_s3 && (row_s3[0] == KB[1]) && (col_s3[0] == KB[0]);
	end

	assign bank_wdata = pix_s3;

endmodule

@@ rtl/dbs_blend.sv @@
module dbs_blend import dbs_pkg::*; #(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smp_ctl_t                        ctl_s4,
	input  logic [FRAC_BITS-1:0]            fr_s4,
	input  logic [FRAC_BITS-1:0]            fc_s4,
	input  logic [NBANK-1:0][PIXEL_BITS-1:0] bank_rdata,
	output logic                            res_valid,
	output logic                            res_inside,
	output logic [PIXEL_BITS-1:0]           res_value
);

	localparam int WF_W   = FRAC_BITS + 1;
	localparam int W_W    = 2 * WF_W;
	localparam int PROD_W = PIXEL_BITS + W_W + 1;
	localparam int ACC_W  = PROD_W + 2;
	localparam logic [WF_W-1:0]         ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [ACC_W-1:0] RND   = ACC_W'(longint'(1) << (2 * FRAC_BITS - 1));

	// One-dimensional weights
	logic [WF_W-1:0] wr [2];
	logic [WF_W-1:0] wc [2];

	always_comb begin
		wr[0] = ONE_F - {1'b0, fr_s4};
		wr[1] = {1'b0, fr_s4};
		wc[0] = ONE_F - {1'b0, fc_s4};
		wc[1] = {1'b0, fc_s4};
	end

	logic                         vld_s5, in_s5, vld_s6, in_s6, vld_s7, in_s7;
	logic [W_W-1:0]               w_s5 [NBANK];
	logic signed [PIXEL_BITS-1:0] n_s5 [NBANK];
	logic signed [PROD_W-1:0]     p_s6 [NBANK];
	logic signed [ACC_W-1:0]      s01_s7, s23_s7;

	// Neighbour k = {row step, column step}; a neighbour with zero weight reads as zero
	for (genvar g = 0; g < NBANK; g++) begin : g_nb
		localparam logic [1:0] KB = 2'(g);
		logic [1:0] sel;
		logic       use_px;

		always_comb begin
			sel    = {ctl_s4.row_odd ^ KB[1], ctl_s4.col_odd ^ KB[0]};
			use_px = ctl_s4.in_img && (!KB[1] || (fr_s4 != '0)) && (!KB[0] || (fc_s4 != '0));
		end

		always_ff @(posedge clk) begin
			w_s5[g] <= W_W'(wr[KB[1]]) * W_W'(wc[KB[0]]);
			n_s5[g] <= use_px ? bank_rdata[sel] : '0;
			p_s6[g] <= n_s5[g] * $signed({1'b0, w_s5[g]});
		end
	end

	// Pairwise sums
	always_ff @(posedge clk) begin
		s01_s7 <= ACC_W'(p_s6[0]) + ACC_W'(p_s6[1]);
		s23_s7 <= ACC_W'(p_s6[2]) + ACC_W'(p_s6[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			in_s5  <= 1'b0;
			in_s6  <= 1'b0;
			in_s7  <= 1'b0;
		end else begin
			vld_s5 <= ctl_s4.valid;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			in_s5  <= ctl_s4.in_img;
			in_s6  <= in_s5;
			in_s7  <= in_s6;
		end
	end

	// Round half up, then drop the weight fraction
	logic signed [ACC_W-1:0] total;

	always_comb begin
		total     = s01_s7 + s23_s7 + RND;
		res_value = PIXEL_BITS'(total >>> (2 * FRAC_BITS));
	end

	assign res_valid  = vld_s7;
	assign res_inside = in_s7;

endmodule

@@ rtl/dbs_fifo.sv @@
module dbs_fifo import dbs_pkg::*; #(
	parameter int WIDTH = 17,
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             out_valid,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_W = clog2_min1(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = data_q[rd_ptr_q];

endmodule

@@ rtl/deformable_bilinear_sampler_top.sv @@
// Deformable bilinear sampler: one image plane held in four pixel banks.
// Input stream (s_axis_*): tuser selects a pixel write or a sample request.
// A write stores one pixel and gives no result. A sample forms the point
// out*stride - pad + tap*dilation + offset on each axis and returns the
// bilinear blend of the four neighbours, or zero with tuser low when the
// point lies outside the image.
// Output stream (m_axis_*): tdata holds the sample, tuser the inside flag.
// Register port (cfg_*): index and data, always ready; write only while idle.
// Throughput: one request per cycle while s_axis_tready is high, from the four
// single-port banks split by row and column parity, so the four neighbours are
// read in one access. Each result passes through the front and blend pipelines
// and the result queue. Up to 16 samples may be outstanding; s_axis_tready falls
// when the result queue plus the pipeline would overflow, so a stalled receiver
// holds back the input after 16 outstanding samples and nothing is lost.
// Reset clears the registers to a 64x64 image, no padding, unit stride and
// dilation, and empties the pipeline; pixel contents are undefined until
// written.
module deformable_bilinear_sampler_top import dbs_pkg::*; #(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int MAX_KERNEL = DEF_MAX_KERNEL,
	localparam int POS_W      = clog2_min1(MAX_DIM),
	localparam int TAP_W      = clog2_min1(MAX_KERNEL),
	localparam int ADDR_W     = clog2_min1(MAX_DIM * MAX_DIM),
	localparam int IN_BITS    = ADDR_W + PIXEL_BITS + 2 * POS_W + 2 * TAP_W + 2 * OFF_W,
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// requests
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: pixel_addr, pixel_value, out_row, out_col, tap_row, tap_col,
	//        offset_rows, offset_cols
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,
	// tuser: command
	input  logic                   s_axis_tuser,
	// results
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: sample_value
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,
	// tuser: inside_image
	output logic                   m_axis_tuser
);

	localparam int HALF    = (MAX_DIM + 1) / 2;
	localparam int BANK_D  = HALF * HALF;
	localparam int BANK_AW = clog2_min1(BANK_D);
	localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int RES_W   = PIXEL_BITS + 1;

	// Field positions in the input tdata
	localparam int PV_LO = ADDR_W;
	localparam int OR_LO = PV_LO + PIXEL_BITS;
	localparam int OC_LO = OR_LO + POS_W;
	localparam int TR_LO = OC_LO + POS_W;
	localparam int TC_LO = TR_LO + TAP_W;
	localparam int FR_LO = TC_LO + TAP_W;
	localparam int FC_LO = FR_LO + OFF_W;

	logic                           in_take, out_take;
	logic [NBANK-1:0]               bank_we;
	logic [NBANK-1:0][BANK_AW-1:0]  bank_addr;
	logic [PIXEL_BITS-1:0]          bank_wdata;
	logic [NBANK-1:0][PIXEL_BITS-1:0] bank_rdata;
	smp_ctl_t                       ctl_s4;
	logic [FRAC_BITS-1:0]           fr_s4, fc_s4;
	logic                           res_valid, res_inside;
	logic [PIXEL_BITS-1:0]          res_value;
	logic [RES_W-1:0]               head;
	logic [CNT_W-1:0]               credit_q;

	assign cfg_ready = 1'b1;
	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign out_take  = m_axis_tvalid && m_axis_tready;

	// Samples in flight or queued; the queue always has room for them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CNT_W'(in_take && (s_axis_tuser == CMD_SAMPLE))
				- CNT_W'(out_take);
		end
	end

	assign s_axis_tready = (credit_q < CNT_W'(FIFO_DEPTH));

	dbs_front #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_KERNEL (MAX_KERNEL)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_take        (in_take),
		.in_cmd         (s_axis_tuser),
		.in_pixel_addr  (s_axis_tdata[ADDR_W-1:0]),
		.in_pixel_value (s_axis_tdata[PV_LO +: PIXEL_BITS]),
		.in_out_row     (s_axis_tdata[OR_LO +: POS_W]),
		.in_out_col     (s_axis_tdata[OC_LO +: POS_W]),
		.in_tap_row     (s_axis_tdata[TR_LO +: TAP_W]),
		.in_tap_col     (s_axis_tdata[TC_LO +: TAP_W]),
		.in_offset_rows (s_axis_tdata[FR_LO +: OFF_W]),
		.in_offset_cols (s_axis_tdata[FC_LO +: OFF_W]),
		.bank_we        (bank_we),
		.bank_addr      (bank_addr),
		.bank_wdata     (bank_wdata),
		.ctl_s4         (ctl_s4),
		.fr_s4          (fr_s4),
		.fc_s4          (fc_s4)
	);

	// Pixel banks by {row parity, column parity}
	for (genvar g = 0; g < NBANK; g++) begin : g_ram
		dbs_ram #(
			.WIDTH (PIXEL_BITS),
			.DEPTH (BANK_D)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[g]),
			.addr  (bank_addr[g]),
			.wdata (bank_wdata),
			.rdata (bank_rdata[g])
		);
	end

	dbs_blend #(
		.PIXEL_BITS (PIXEL_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s4     (ctl_s4),
		.fr_s4      (fr_s4),
		.fc_s4      (fc_s4),
		.bank_rdata (bank_rdata),
		.res_valid  (res_valid),
		.res_inside (res_inside),
		.res_value  (res_value)
	);

	dbs_fifo #(
		.WIDTH (RES_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data ({res_inside, res_value}),
		.pop       (out_take),
		.out_valid (m_axis_tvalid),
		.out_data  (head)
	);

	assign m_axis_tdata = OUT_DATA_W'(head[PIXEL_BITS-1:0]);
	assign m_axis_tuser = head[PIXEL_BITS];

endmodule
